FILE: rtl/core/serial_command_recognizer_assert.svh
// Assertion macros for the serial command recognizer checker.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef SERIAL_COMMAND_RECOGNIZER_ASSERT_SVH
`define SERIAL_COMMAND_RECOGNIZER_ASSERT_SVH

// cond must hold at every clock outside reset
`define SCR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trig in one cycle implies cons in the next
`define SCR_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/scr_pkg.sv
// Shared types, constants and keyword table for the serial command recognizer.
// No dependencies.
package scr_pkg;

	localparam int BufDepth = 8;
	localparam int IdxW     = $clog2(BufDepth + 1);
	localparam int SlotW    = $clog2(BufDepth);
	localparam int KwMax    = 8;
	localparam int NumKw    = 6;
	localparam int CmdW     = 3;
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);
	localparam int QCntW    = $clog2(QDepth + 1);
	localparam int CfgW     = 8;
	localparam int CfgIdxW  = 2;

	localparam logic [CfgIdxW-1:0] CfgMinLength = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDelimiter = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgEndChar   = 2'd2;

	localparam logic [2:0] MinLengthRst = 3'd4;
	localparam logic [7:0] DelimiterRst = 8'h0D;
	localparam logic [7:0] EndCharRst   = 8'h04;

	localparam logic [CmdW-1:0] CmdHelp    = 3'd0;
	localparam logic [CmdW-1:0] CmdWhoami  = 3'd1;
	localparam logic [CmdW-1:0] CmdBoot    = 3'd2;
	localparam logic [CmdW-1:0] CmdShip    = 3'd3;
	localparam logic [CmdW-1:0] CmdReset   = 3'd4;
	localparam logic [CmdW-1:0] CmdPcInfo  = 3'd5;
	localparam logic [CmdW-1:0] CmdUnknown = 3'd6;

	// keywords in match order, zero padded
	localparam logic [7:0] KwText [NumKw][KwMax] = '{
		'{8'h68, 8'h65, 8'h6c, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h6f, 8'h61, 8'h6d, 8'h69, 8'h00, 8'h00},
		'{8'h62, 8'h6f, 8'h6f, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h73, 8'h68, 8'h69, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h72, 8'h65, 8'h73, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
		'{8'h01, 8'h10, 8'h03, 8'h3f, 8'h3f, 8'h3f, 8'h30, 8'h00}
	};

	typedef logic [KwMax-1:0][7:0] line_t;

	typedef enum logic [1:0] {
		KIND_DONE,
		KIND_IGNORED,
		KIND_DATA,
		KIND_WAKE
	} kind_t;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic            wake;
		logic [CmdW-1:0] command_code;
		logic            byte_ignored;
	} result_t;

	typedef struct packed {
		kind_t kind;
		line_t line;
	} q_entry_t;

	// line equals keyword k up to and including the keyword's terminating zero
	function automatic logic kw_match(input line_t line, input int k);
		logic ok;
		logic stop;
		ok   = 1'b1;
		stop = 1'b0;
		for (int i = 0; i < KwMax; i++) begin
			if (!stop) begin
				if (line[i] != KwText[k][i])
					ok = 1'b0;
				if (KwText[k][i] == 8'h00)
					stop = 1'b1;
			end
		end
		return ok & stop;
	endfunction

	function automatic logic [CmdW-1:0] classify(input line_t line);
		logic [CmdW-1:0] code;
		code = CmdUnknown;
		for (int k = NumKw - 1; k >= 0; k--) begin
			if (kw_match(line, k))
				code = CmdW'(k);
		end
		return code;
	endfunction

endpackage

FILE: rtl/core/scr_front.sv
// Front end: config registers, line buffer, fill index and busy flag.
// Classifies each item and hands a queue entry to the back end. Uses scr_pkg.
module scr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  scr_pkg::rx_item_t             rx_item,
	input  logic                          cfg_we,
	input  logic [scr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [scr_pkg::CfgW-1:0]      cfg_data,
	output scr_pkg::q_entry_t             entry
);

	logic [2:0]                  min_len_q;
	logic [7:0]                  delim_q;
	logic [7:0]                  endc_q;
	logic [7:0]                  line_q [scr_pkg::BufDepth];
	logic [7:0]                  line_next [scr_pkg::BufDepth];
	logic [scr_pkg::IdxW-1:0]    fill_q;
	logic [scr_pkg::IdxW-1:0]    fill_next;
	logic                        busy_q;
	logic                        busy_next;
	logic [scr_pkg::SlotW-1:0]   wr_slot;
	logic [scr_pkg::IdxW-1:0]    count;
	logic                        term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= scr_pkg::MinLengthRst;
			delim_q   <= scr_pkg::DelimiterRst;
			endc_q    <= scr_pkg::EndCharRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scr_pkg::CfgMinLength: min_len_q <= cfg_data[2:0];
				scr_pkg::CfgDelimiter: delim_q   <= cfg_data;
				scr_pkg::CfgEndChar:   endc_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_slot   = (fill_q >= scr_pkg::IdxW'(scr_pkg::BufDepth)) ?
			'0 : fill_q[scr_pkg::SlotW-1:0];
		count     = scr_pkg::IdxW'(wr_slot) + scr_pkg::IdxW'(1);
		term      = ((rx_item.rx_byte == delim_q) || (rx_item.rx_byte == endc_q)) &&
			(count > scr_pkg::IdxW'(min_len_q));
		line_next = line_q;
		fill_next = fill_q;
		busy_next = busy_q;
		entry.kind = scr_pkg::KIND_DATA;
		priority if (rx_item.func) begin
			busy_next  = 1'b0;
			fill_next  = '0;
			entry.kind = scr_pkg::KIND_DONE;
		end else if (busy_q) begin
			entry.kind = scr_pkg::KIND_IGNORED;
		end else if (term) begin
			// terminator slot reads as zero so the line is cut there
			line_next[wr_slot] = 8'h00;
			fill_next  = count;
			busy_next  = 1'b1;
			entry.kind = scr_pkg::KIND_WAKE;
		end else begin
			line_next[wr_slot] = rx_item.rx_byte;
			fill_next = (count > scr_pkg::IdxW'(scr_pkg::BufDepth - 1)) ? '0 : count;
		end
		for (int i = 0; i < scr_pkg::KwMax; i++)
			entry.line[i] = line_next[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			busy_q <= 1'b0;
			for (int i = 0; i < scr_pkg::BufDepth; i++)
				line_q[i] <= 8'h00;
		end else if (accept) begin
			fill_q <= fill_next;
			busy_q <= busy_next;
			line_q <= line_next;
		end
	end

endmodule

FILE: rtl/core/scr_queue.sv
// Short FIFO of classified items between front and back end.
// Uses scr_pkg for the entry type and depth.
module scr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  scr_pkg::q_entry_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic              not_empty,
	output scr_pkg::q_entry_t rd_data
);

	scr_pkg::q_entry_t          mem_q [scr_pkg::QDepth];
	logic [scr_pkg::QPtrW-1:0]  wr_ptr_q;
	logic [scr_pkg::QPtrW-1:0]  rd_ptr_q;
	logic [scr_pkg::QCntW-1:0]  cnt_q;
	logic                       do_wr;
	logic                       do_rd;

	assign full      = (cnt_q == scr_pkg::QCntW'(scr_pkg::QDepth));
	assign not_empty = (cnt_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + scr_pkg::QPtrW'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + scr_pkg::QPtrW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + scr_pkg::QCntW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - scr_pkg::QCntW'(1);
		end
	end

endmodule

FILE: rtl/core/scr_back.sv
// Back end: keyword compare and the output register seen by the consumer.
// Uses scr_pkg for the keyword table and result type.
module scr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  scr_pkg::q_entry_t q_data,
	output logic              q_take,
	input  logic              pop,
	output logic              empty,
	output scr_pkg::result_t  result
);

	scr_pkg::result_t res_d;
	scr_pkg::result_t result_q;
	logic             valid_q;

	// refill the output register when it is free or being drained
	assign q_take = q_valid && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = result_q;

	always_comb begin
		res_d = '0;
		unique case (q_data.kind)
			scr_pkg::KIND_WAKE: begin
				res_d.wake         = 1'b1;
				res_d.command_code = scr_pkg::classify(q_data.line);
			end
			scr_pkg::KIND_IGNORED: res_d.byte_ignored = 1'b1;
			scr_pkg::KIND_DONE, scr_pkg::KIND_DATA: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_take)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_take)
			result_q <= res_d;
	end

endmodule

FILE: rtl/core/serial_command_recognizer.sv
// Serial command recognizer: one item accepted per cycle while full is low.
// A result passes through the item queue and then the output register before it shows
// on the result ports; throughput one item per cycle while the consumer pops each result.
// full rises only when the four-entry item queue backs up behind a stalled pop.
// Reset (arst_n low) clears the line buffer, fill index, busy flag, item queue and output
// valid and loads the register defaults: min length 4, delimiter 0x0D, end char 0x04.
module serial_command_recognizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  scr_pkg::rx_item_t            rx_item,
	output logic                         empty,
	input  logic                         pop,
	output scr_pkg::result_t             result,
	input  logic                         cfg_we,
	input  logic [scr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [scr_pkg::CfgW-1:0]     cfg_data
);

	scr_pkg::q_entry_t front_entry;
	scr_pkg::q_entry_t q_data;
	logic              accept;
	logic              q_valid;
	logic              q_take;

	assign accept = push && !full;

	scr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_item   (rx_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.entry     (front_entry)
	);

	scr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.wr_data   (front_entry),
		.full      (full),
		.rd_en     (q_take),
		.not_empty (q_valid),
		.rd_data   (q_data)
	);

	scr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_take  (q_take),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

FILE: rtl/core/scr_checker.sv
// Port-level checks on the result side of the serial command recognizer.
// Uses scr_pkg and serial_command_recognizer_assert.svh; bound to the top level.
`include "serial_command_recognizer_assert.svh"

module scr_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input scr_pkg::result_t result
);

	`SCR_ASSERT_ALWAYS(a_wake_xor_ignored, empty || !(result.wake && result.byte_ignored), "wake and byte_ignored both set")
	`SCR_ASSERT_ALWAYS(a_code_only_on_wake, empty || result.wake || result.command_code == scr_pkg::CmdHelp, "command code without wake")
	`SCR_ASSERT_ALWAYS(a_code_range, empty || result.command_code <= scr_pkg::CmdUnknown, "command code out of range")
	`SCR_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(result), "stalled result changed")

endmodule

bind serial_command_recognizer scr_checker u_scr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
